// ===== hw/rtl/cpbi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbi_pkg
// Shared types and constants of the character position bitmap index.
// ----------------------------------------------------------------------------
package cpbi_pkg;

  // Item operation codes. Code 3 has no meaning and is ignored.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_ACCESS = 2'd2
  } state_e;

  // One 32-byte slot of the bitmap is one memory row, one bit per char code.
  localparam int SLOT_BYTES = 32;
  localparam int ROW_BITS   = SLOT_BYTES * 8;
  localparam int REGION_CAP = 64;
  localparam logic [7:0] CODE_EMPTY = 8'd1;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;    // latch the item and start the row read
    logic clr_start;  // restart the clearing sweep
    logic clr_step;   // zero one row of the sweep
    logic access;     // finish the insert or query on the row read
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;     // the sweep is at its final row
    logic query_last;   // held item is a query ending its string
    logic out_blocked;  // output register is full and stalled
  } sts_t;

endpackage

// ===== hw/rtl/char_position_bitmap_index.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_position_bitmap_index
// Character position bitmap index of one pack, fed one character per item.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_stall_o  op, string_length, position,
//                                               char_code, last
//   out      output     out_valid_o / out_stall_i maybe_present
//
// An insert or query item first reads its bitmap row from the row memory
// and then updates or tests it.
// A clear item starts the clearing sweep, which zeroes one row per cycle
// over all 64 + MAX_POSITIONS rows (128 by default); after reset the same
// sweep runs before the first item is taken.
// A query result waits in the output register; a stalled output only holds
// the block when the next query result is ready to be written.
//
// The bitmap is kept as rows of 32 bytes, one row per slot. The string length
// selects a region of slots (0 for the empty string, else the next power of
// two of the length, capped at 64), and the character position is added to
// it to form the row. The character code picks the bit within the row.
// A query ANDs the bit tests of all its characters and reports the result
// with its last character, then restarts the accumulator.
// ----------------------------------------------------------------------------
module char_position_bitmap_index #(
  parameter int MAX_POSITIONS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [11:0] string_length_i,
  input  logic [5:0]  position_i,
  input  logic [7:0]  char_code_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        maybe_present_o
);
  import cpbi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences the sweep and each item's read and update.
  cpbi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the bitmap rows, the accumulator and the output.
  cpbi_dp #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .string_length_i (string_length_i),
    .position_i      (position_i),
    .char_code_i     (char_code_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .maybe_present_o (maybe_present_o)
  );

  // The sweep and a row update never share the memory write port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.clr_step && cmd.access))
    else $error("clearing sweep and row update in the same cycle");

  // An accepted clear item keeps the input stalled while the sweep runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && op_i == OP_CLEAR) |=> (in_stall_o && cmd.clr_step))
    else $error("clear item did not start the sweep");

  // An accepted insert or query is followed by its row access cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (op_i == OP_INSERT || op_i == OP_QUERY))
      |=> in_stall_o)
    else $error("item accepted before the previous row access");

  // A result is only written when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.access && sts.query_last) |-> !sts.out_blocked)
    else $error("query result would overwrite a pending result");

endmodule

// ===== hw/rtl/cpbi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbi_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module cpbi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cpbi_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbi_ctrl
// Sequencer: clearing sweep, item acceptance and the row access step.
// ----------------------------------------------------------------------------
module cpbi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      op_i,
  output logic            in_stall_o,
  input  cpbi_pkg::sts_t  sts_i,
  output cpbi_pkg::cmd_t  cmd_o
);
  import cpbi_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (op_i)
            OP_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d         = ST_CLEAR;
            end
            OP_INSERT, OP_QUERY: begin
              state_d = ST_ACCESS;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_ACCESS: begin
        // A query result waits here until the output register can take it.
        if (!(sts_i.query_last && sts_i.out_blocked)) begin
          cmd_o.access = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== hw/rtl/cpbi_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbi_dp
// Datapath: slot address generation, bitmap rows, query accumulator, output.
// ----------------------------------------------------------------------------
module cpbi_dp #(
  parameter int MAX_POSITIONS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cpbi_pkg::cmd_t  cmd_i,
  output cpbi_pkg::sts_t  sts_o,
  input  logic [1:0]      op_i,
  input  logic [11:0]     string_length_i,
  input  logic [5:0]      position_i,
  input  logic [7:0]      char_code_i,
  input  logic            last_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            maybe_present_o
);
  import cpbi_pkg::*;

  localparam int DEPTH  = REGION_CAP + MAX_POSITIONS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Smallest power of two that is at least len, for len from 1 to 64.
  function automatic logic [6:0] next_pow2(input logic [6:0] len);
    logic [6:0] v;
    begin
      v = len - 7'd1;
      v = v | (v >> 1);
      v = v | (v >> 2);
      v = v | (v >> 4);
      return v + 7'd1;
    end
  endfunction

  logic              len_zero;
  logic              len_big;
  logic [6:0]        region;
  logic [6:0]        slot;
  logic              cap_located;
  logic [7:0]        cap_code;
  logic [ADDR_W-1:0] cap_row;

  always_comb begin
    len_zero = (string_length_i == 12'd0);
    len_big  = (string_length_i > 12'(REGION_CAP));
    region   = len_big ? 7'(REGION_CAP) : next_pow2(string_length_i[6:0]);
    if (len_zero) begin
      slot        = 7'd0;
      cap_code    = CODE_EMPTY;
      cap_located = 1'b1;
    end else begin
      slot        = region + {1'b0, position_i};
      cap_code    = char_code_i;
      cap_located = ({1'b0, position_i} < 7'(MAX_POSITIONS))
                 && ({6'd0, position_i} < string_length_i);
    end
    cap_row = slot[ADDR_W-1:0];
  end

  logic [ADDR_W-1:0] row_q;
  logic [7:0]        code_q;
  logic              located_q;
  logic              insert_q;
  logic              last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_q     <= cap_row;
      code_q    <= cap_code;
      located_q <= cap_located;
      insert_q  <= (op_i == OP_INSERT);
      last_q    <= last_i;
    end
  end

  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    if (cmd_i.clr_start) begin
      clr_cnt_d = '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ROW_BITS-1:0] ram_wdata;
  logic [ROW_BITS-1:0] ram_rdata;

  assign ram_we    = cmd_i.clr_step || (cmd_i.access && insert_q && located_q);
  assign ram_waddr = cmd_i.clr_step ? clr_cnt_q : row_q;
  assign ram_wdata = cmd_i.clr_step ? '0
                                    : (ram_rdata | (ROW_BITS'(1) << code_q));

  cpbi_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (cap_row),
    .rdata_o (ram_rdata)
  );

  // Running AND of the current query's bit tests.
  logic match_q, match_d;
  logic hit;
  logic result;
  logic out_valid_q, out_valid_d;
  logic out_data_q, out_data_d;
  logic emit;

  always_comb begin
    hit    = !located_q || ram_rdata[code_q];
    result = match_q && hit;
    emit   = cmd_i.access && !insert_q && last_q;
    match_d = match_q;
    if (cmd_i.clr_start) begin
      match_d = 1'b1;
    end else if (cmd_i.access && !insert_q) begin
      match_d = last_q ? 1'b1 : result;
    end
    out_valid_d = (out_valid_q && out_stall_i) || emit;
    out_data_d  = emit ? result : out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o       = out_valid_q;
  assign maybe_present_o   = out_data_q;
  assign sts_o.clr_last    = (clr_cnt_q == ADDR_W'(DEPTH - 1));
  assign sts_o.query_last  = !insert_q && last_q;
  assign sts_o.out_blocked = out_valid_q && out_stall_i;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the character position bitmap index. A scripted
// opening covers empty, long and out-of-range strings, clears and the query
// accumulator. It is followed by random insert and query strings with noise,
// checked against a bit-level shadow of the bitmap.
// ----------------------------------------------------------------------------
module tb;
  import cpbi_pkg::*;

  localparam int MAX_POS      = 64;
  localparam int STORE_BYTES  = 4096;
  localparam int ITEM_TARGET  = 1000;
  localparam int QUIET_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 4000;
  localparam int POOL_SIZE    = 16;
  // The package names no operation for code 3; the block ignores it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i            = OP_CLEAR;
  logic [11:0] string_length_i = '0;
  logic [5:0]  position_i      = '0;
  logic [7:0]  char_code_i     = '0;
  logic        last_i          = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic        maybe_present_o;

  always #10 clk_i = ~clk_i;

  char_position_bitmap_index #(
    .MAX_POSITIONS(MAX_POS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .string_length_i(string_length_i),
    .position_i     (position_i),
    .char_code_i    (char_code_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .maybe_present_o(maybe_present_o)
  );

  // Shadow copy of the bitmap and of the running AND of a query's bit tests.
  logic [7:0] shadow_bitmap [STORE_BYTES];
  logic       shadow_match;

  // Presence answers still owed by the block, oldest first.
  logic       presence_q [$];

  int  mismatch_cnt = 0;
  int  items_sent   = 0;
  int  stuck_cycles = 0;
  bit  quiet        = 1'b0;  // no idling on either side near the end of the run
  bit  hold_req     = 1'b0;  // asks the receiver for one long hold-off

  // Strings already inserted, kept so that queries can hit them.
  logic [7:0]  pool_text [POOL_SIZE][MAX_POS];
  logic [11:0] pool_len  [POOL_SIZE];
  int          pool_used = 0;
  logic [7:0]  text_buf  [MAX_POS];

  // Scripted opening. Where fixed is set, want is the answer that must come
  // back; every other query is judged by the shadow model.
  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] len;
    logic [5:0]  pos;
    logic [7:0]  code;
    logic        last;
    logic        fixed;
    logic        want;
  } script_row_t;

  script_row_t script [0:24] = '{
    // Fresh store: an empty string and a plain string are both absent.
    '{OP_QUERY,  12'd0,    6'd0,  8'h01, 1'b1, 1'b1, 1'b0},
    '{OP_QUERY,  12'd5,    6'd4,  8'hFF, 1'b1, 1'b1, 1'b0},
    // A position past the string length tests nothing, so the query passes.
    '{OP_QUERY,  12'd3,    6'd63, 8'h00, 1'b1, 1'b1, 1'b1},
    '{OP_UNUSED, 12'd4095, 6'd63, 8'hFF, 1'b1, 1'b0, 1'b0},
    // The empty string always maps to code 1 at position 0.
    '{OP_INSERT, 12'd0,    6'd63, 8'hFF, 1'b1, 1'b0, 1'b0},
    '{OP_QUERY,  12'd0,    6'd17, 8'h00, 1'b1, 1'b1, 1'b1},
    // Top corner of the store: longest length, last position, top code.
    '{OP_INSERT, 12'd4095, 6'd63, 8'hFF, 1'b1, 1'b0, 1'b0},
    '{OP_QUERY,  12'd4095, 6'd63, 8'hFF, 1'b1, 1'b1, 1'b1},
    '{OP_INSERT, 12'd64,   6'd0,  8'h80, 1'b0, 1'b0, 1'b0},
    '{OP_INSERT, 12'd64,   6'd63, 8'h7F, 1'b1, 1'b0, 1'b0},
    '{OP_QUERY,  12'd64,   6'd0,  8'h80, 1'b0, 1'b0, 1'b0},
    '{OP_QUERY,  12'd64,   6'd63, 8'h7F, 1'b1, 1'b0, 1'b0},
    // Lengths above 64 share the 64 region.
    '{OP_QUERY,  12'd100,  6'd0,  8'h80, 1'b0, 1'b0, 1'b0},
    '{OP_QUERY,  12'd100,  6'd63, 8'h7F, 1'b1, 1'b0, 1'b0},
    '{OP_QUERY,  12'd32,   6'd0,  8'h80, 1'b1, 1'b0, 1'b0},
    // A miss early in a query survives an insert and spoils a later hit.
    '{OP_QUERY,  12'd2,    6'd0,  8'h54, 1'b0, 1'b0, 1'b0},
    '{OP_INSERT, 12'd1,    6'd0,  8'h55, 1'b1, 1'b0, 1'b0},
    '{OP_QUERY,  12'd1,    6'd0,  8'h55, 1'b1, 1'b0, 1'b0},
    // An insert past the string length sets nothing.
    '{OP_INSERT, 12'd2,    6'd5,  8'h09, 1'b1, 1'b0, 1'b0},
    '{OP_QUERY,  12'd8,    6'd3,  8'h09, 1'b1, 1'b0, 1'b0},
    // A clear in the middle of a failing query restarts the accumulator.
    '{OP_QUERY,  12'd5,    6'd2,  8'h33, 1'b0, 1'b0, 1'b0},
    '{OP_CLEAR,  12'hAAA,  6'd42, 8'h5A, 1'b0, 1'b0, 1'b0},
    '{OP_QUERY,  12'd9,    6'd40, 8'hC3, 1'b1, 1'b1, 1'b1},
    '{OP_QUERY,  12'd4095, 6'd63, 8'hFF, 1'b1, 1'b1, 1'b0},
    '{OP_INSERT, 12'd7,    6'd6,  8'h00, 1'b1, 1'b0, 1'b0}
  };

  task automatic note_mismatch(input string what);
    mismatch_cnt++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // First slot of the size-class region that a string length selects.
  function automatic int unsigned region_of(input logic [11:0] len);
    int unsigned r;
    r = 1;
    if (len == 0) return 0;
    if (len > 64) return 64;
    while (r < len) r = r << 1;
    return r;
  endfunction

  // Applies one accepted item to the shadow bitmap. gives is set when the item
  // ends a query, and present then holds the answer it must produce.
  task automatic index_item(input logic [1:0] op, input logic [11:0] len,
                            input logic [5:0] pos, input logic [7:0] code,
                            input logic last, output bit gives, output logic present);
    int unsigned lim, chr, p, byte_at;
    bit          in_range;
    logic        hit;
    gives    = 1'b0;
    present  = 1'b0;
    chr      = code;
    p        = pos;
    in_range = 1'b1;
    lim      = (len < MAX_POS) ? len : MAX_POS;
    if (len == 0) begin
      chr = CODE_EMPTY;
      p   = 0;
    end else if (p >= lim) begin
      in_range = 1'b0;
    end
    byte_at = ((region_of(len) + p) * SLOT_BYTES + (chr >> 3)) % STORE_BYTES;
    case (op)
      OP_CLEAR: begin
        foreach (shadow_bitmap[i]) shadow_bitmap[i] = '0;
        shadow_match = 1'b1;
      end
      OP_INSERT: begin
        if (in_range) shadow_bitmap[byte_at][chr & 7] = 1'b1;
      end
      OP_QUERY: begin
        hit = in_range ? shadow_bitmap[byte_at][chr & 7] : 1'b1;
        shadow_match = shadow_match & hit;
        if (last) begin
          gives        = 1'b1;
          present      = shadow_match;
          shadow_match = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // Offers one item, possibly after a random gap, and waits until it is taken.
  // Always entered and left right after a rising edge.
  task automatic send_item(input logic [1:0] op, input logic [11:0] len,
                           input logic [5:0] pos, input logic [7:0] code,
                           input logic last, input bit gap_ok,
                           input bit fixed, input logic want);
    bit   gives;
    logic pred;
    int   gap;
    if (gap_ok && !quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    string_length_i <= len;
    position_i      <= pos;
    char_code_i     <= code;
    last_i          <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    index_item(op, len, pos, code, last, gives, pred);
    if (gives) presence_q = {presence_q, (fixed ? want : pred)};
    if (op != OP_UNUSED) items_sent++;
    if (items_sent >= ITEM_TARGET - QUIET_ITEMS) quiet = 1'b1;
  endtask

  // Sends the string held in text_buf, one character per item.
  task automatic send_string(input logic [1:0] op, input logic [11:0] len);
    int n;
    n = (len == 0) ? 1 : ((len > MAX_POS) ? MAX_POS : len);
    for (int i = 0; i < n; i++) begin
      send_item(op, len, 6'(i), text_buf[i], i == n - 1, 1'b1, 1'b0, 1'b0);
    end
  endtask

  // Mostly short strings, some up to the indexed limit, a few far longer.
  function automatic logic [11:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 12'($urandom_range(0, 8));
    if (r < 90) return 12'($urandom_range(9, 64));
    return 12'($urandom_range(65, 4095));
  endfunction

  // Waits with the input idle until every owed answer has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (presence_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none near
  // the end.
  initial begin : receiver
    int burst;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req    = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 17);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Every accepted result must match the oldest owed answer.
  always @(posedge clk_i) begin : result_check
    logic want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (presence_q.size() == 0) begin
        note_mismatch($sformatf("result %0b with no query pending", maybe_present_o));
      end else begin
        want = presence_q.pop_front();
        if (maybe_present_o !== want) begin
          note_mismatch($sformatf("maybe_present %0b, expected %0b", maybe_present_o, want));
        end
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int          pick, slot, n;
    logic [11:0] len;
    bit          held, paused;
    held   = 1'b0;
    paused = 1'b0;
    foreach (shadow_bitmap[i]) shadow_bitmap[i] = '0;
    shadow_match = 1'b1;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      send_item(script[i].op, script[i].len, script[i].pos, script[i].code,
                script[i].last, 1'b1, script[i].fixed, script[i].want);
    end
    drain_results();

    while (items_sent < ITEM_TARGET) begin
      // Fill the block while the receiver holds off: back-to-back queries,
      // each of which ends a string and so owes an answer.
      if (!held && items_sent >= 350) begin
        held     = 1'b1;
        hold_req = 1'b1;
        repeat (16) begin
          send_item(OP_QUERY, 12'd0, 6'($urandom), 8'($urandom), 1'b1,
                    1'b0, 1'b0, 1'b0);
        end
      end
      if (!paused && items_sent >= 600) begin
        paused = 1'b1;
        drain_results();
      end

      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_item(OP_CLEAR, 12'($urandom), 6'($urandom), 8'($urandom), 1'($urandom),
                  1'b1, 1'b0, 1'b0);
        pool_used = 0;
      end else if (pick < 40) begin
        len = pick_length();
        foreach (text_buf[i]) text_buf[i] = 8'($urandom);
        send_string(OP_INSERT, len);
        if (pool_used < POOL_SIZE) begin
          slot = pool_used;
          pool_used++;
        end else begin
          slot = $urandom_range(0, POOL_SIZE - 1);
        end
        pool_len[slot] = len;
        foreach (text_buf[i]) pool_text[slot][i] = text_buf[i];
      end else if (pick < 75 && pool_used > 0) begin
        // Query a stored string, now and then with one character altered.
        slot = $urandom_range(0, pool_used - 1);
        len  = pool_len[slot];
        foreach (text_buf[i]) text_buf[i] = pool_text[slot][i];
        n = (len == 0) ? 1 : ((len > MAX_POS) ? MAX_POS : len);
        if ($urandom_range(0, 2) == 0) text_buf[$urandom_range(0, n - 1)] = 8'($urandom);
        send_string(OP_QUERY, len);
      end else if (pick < 88) begin
        len = pick_length();
        foreach (text_buf[i]) text_buf[i] = 8'($urandom);
        send_string(OP_QUERY, len);
      end else begin
        // Noise: loose items, broken strings, out-of-range positions, code 3.
        len = $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 10));
        send_item(2'($urandom_range(1, 3)), len, 6'($urandom), 8'($urandom),
                  1'($urandom), 1'b1, 1'b0, 1'b0);
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && presence_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
